// ----- sv/dur_pkg.sv -----
// dur_pkg: shared codes, register indexes and command type for the dual uart register block
// no dependencies; imported by dur_ctrl, dur_datapath, dual_uart_register_block and tb
package dur_pkg;

    // action codes
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FEED  = 2'd2;

    // register indexes after the stride divide
    localparam logic [3:0] IDX_MODE_A = 4'd0;
    localparam logic [3:0] IDX_STAT_A = 4'd1;
    localparam logic [3:0] IDX_CMD_A  = 4'd2;
    localparam logic [3:0] IDX_HOLD_A = 4'd3;
    localparam logic [3:0] IDX_MODE_B = 4'd8;
    localparam logic [3:0] IDX_STAT_B = 4'd9;
    localparam logic [3:0] IDX_CMD_B  = 4'd10;
    localparam logic [3:0] IDX_HOLD_B = 4'd11;

    // command field value in bits 6..4 that returns the mode pointer to mr1
    localparam logic [2:0] CMD_RESET_MR = 3'd1;

    // status bits
    localparam logic [7:0] ST_RXRDY = 8'h01;
    localparam logic [7:0] ST_TXRDY = 8'h04;
    localparam logic [7:0] ST_TXEMT = 8'h08;

    typedef struct packed {
        logic capture;  // item accepted, latch payload
        logic exec;     // apply the item to state
        logic load;     // move staged result into the output register
    } dur_cmd_t;

    // transmitter bits are set at reset and never cleared, so only rxrdy varies
    function automatic logic [7:0] status_byte(input logic rxrdy);
        status_byte = ST_TXRDY | ST_TXEMT | (rxrdy ? ST_RXRDY : 8'h00);
    endfunction

endpackage

// ----- sv/dur_ctrl.sv -----
// dur_ctrl: sequencer for the dual uart register block (accept, execute, load result)
// depends on dur_pkg for the command struct
module dur_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    output dur_pkg::dur_cmd_t cmd
);
    import dur_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    // output register can take a new result if empty or being emptied now
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.capture    = 1'b0;
        cmd.exec       = 1'b0;
        cmd.load       = 1'b0;
        state_next     = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_EXEC))
        else $error("item accepted but execute step did not follow");

    a_exec_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> (state_reg == ST_LOAD))
        else $error("execute step not followed by result load");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid_reg)
        else $error("result loaded but output not valid");

    a_load_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && out_valid_reg && !out_ready) |=> (state_reg == ST_LOAD))
        else $error("result overwrote an output that was not taken");

endmodule

// ----- sv/dur_datapath.sv -----
// dur_datapath: register file, mode pointers, receive rings and result register
// depends on dur_pkg; driven by the commands of dur_ctrl
module dur_datapath #(
    parameter int REG_STRIDE = 4,
    parameter int RING_SLOTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dur_pkg::dur_cmd_t cmd,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic [1:0]        action,
    input  logic [5:0]        bus_offset,
    input  logic [7:0]        data_byte,
    input  logic              channel,
    output logic [7:0]        read_data,
    output logic              tx_valid,
    output logic              tx_channel,
    output logic [7:0]        tx_byte,
    output logic              rx_empty_a,
    output logic              rx_empty_b,
    output logic              feed_dropped
);
    import dur_pkg::*;

    localparam int PTR_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int ADDR_W    = $clog2(2 * RING_SLOTS);
    localparam int MEM_DEPTH = 2 * RING_SLOTS;
    // offset / stride as a reciprocal multiply, exact for 6-bit offsets
    localparam int DIV_SHIFT = 8;
    localparam int DIV_MULT  = ((1 << DIV_SHIFT) + REG_STRIDE - 1) / REG_STRIDE;
    localparam int PROD_W    = 15;

    // captured item
    logic [1:0] act_reg;
    logic [3:0] idx_reg;
    logic [7:0] data_reg;
    logic       ch_reg;
    logic [PROD_W-1:0] prod;

    // architectural state
    logic [7:0]       rf_reg [16];
    logic [7:0]       rf_next [16];
    logic             mp_a_reg, mp_a_next;
    logic             mp_b_reg, mp_b_next;
    logic [PTR_W-1:0] head_a_reg, head_a_next;
    logic [PTR_W-1:0] head_b_reg, head_b_next;
    logic [PTR_W-1:0] tail_a_reg, tail_a_next;
    logic [PTR_W-1:0] tail_b_reg, tail_b_next;
    logic             tx_en_reg;

    // staged result
    logic [7:0] rd_st_reg, rd_st_next;
    logic       txv_st_reg, txv_st_next;
    logic       txc_st_reg, txc_st_next;
    logic [7:0] txb_st_reg, txb_st_next;
    logic       drop_st_reg, drop_st_next;
    logic       pop_st_reg, pop_st_next;

    // receive ring memory
    logic [7:0]        ring_mem [MEM_DEPTH];
    logic [7:0]        ring_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;

    logic             empty_a;
    logic             empty_b;
    logic [PTR_W-1:0] feed_head;
    logic [PTR_W-1:0] feed_tail;
    logic [PTR_W-1:0] feed_tail_inc;
    logic [PTR_W-1:0] hold_head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(RING_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] ring_addr(input logic c, input logic [PTR_W-1:0] p);
        ring_addr = c ? (ADDR_W'(p) + ADDR_W'(RING_SLOTS)) : ADDR_W'(p);
    endfunction

    assign prod          = {{(PROD_W-6){1'b0}}, bus_offset} * PROD_W'(DIV_MULT);
    assign empty_a       = (head_a_reg == tail_a_reg);
    assign empty_b       = (head_b_reg == tail_b_reg);
    assign feed_head     = ch_reg ? head_b_reg : head_a_reg;
    assign feed_tail     = ch_reg ? tail_b_reg : tail_a_reg;
    assign feed_tail_inc = ptr_inc(feed_tail);
    assign hold_head     = idx_reg[3] ? head_b_reg : head_a_reg;
    assign mem_waddr     = ring_addr(ch_reg, feed_tail);
    assign mem_raddr     = ring_addr(idx_reg[3], hold_head);

    always_comb
    begin
        rf_next      = rf_reg;
        mp_a_next    = mp_a_reg;
        mp_b_next    = mp_b_reg;
        head_a_next  = head_a_reg;
        head_b_next  = head_b_reg;
        tail_a_next  = tail_a_reg;
        tail_b_next  = tail_b_reg;
        rd_st_next   = rd_st_reg;
        txv_st_next  = txv_st_reg;
        txc_st_next  = txc_st_reg;
        txb_st_next  = txb_st_reg;
        drop_st_next = drop_st_reg;
        pop_st_next  = pop_st_reg;
        mem_we       = 1'b0;
        if (cmd.exec)
        begin
            rd_st_next   = 8'h00;
            txv_st_next  = 1'b0;
            txc_st_next  = 1'b0;
            txb_st_next  = 8'h00;
            drop_st_next = 1'b0;
            pop_st_next  = 1'b0;
            case (act_reg)
                ACT_READ:
                begin
                    unique case (idx_reg)
                        IDX_MODE_A: rd_st_next = rf_reg[{3'b000, mp_a_reg}];
                        IDX_MODE_B: rd_st_next = rf_reg[{3'b100, mp_b_reg}];
                        IDX_STAT_A: rd_st_next = status_byte(!empty_a);
                        IDX_STAT_B: rd_st_next = status_byte(!empty_b);
                        IDX_HOLD_A:
                        begin
                            if (!empty_a)
                            begin
                                pop_st_next = 1'b1;
                                head_a_next = ptr_inc(head_a_reg);
                            end
                        end
                        IDX_HOLD_B:
                        begin
                            if (!empty_b)
                            begin
                                pop_st_next = 1'b1;
                                head_b_next = ptr_inc(head_b_reg);
                            end
                        end
                        default: rd_st_next = rf_reg[idx_reg];
                    endcase
                end
                ACT_WRITE:
                begin
                    unique case (idx_reg)
                        IDX_MODE_A:
                        begin
                            rf_next[{3'b000, mp_a_reg}] = data_reg;
                            mp_a_next = 1'b1;
                        end
                        IDX_MODE_B:
                        begin
                            rf_next[{3'b100, mp_b_reg}] = data_reg;
                            mp_b_next = 1'b1;
                        end
                        IDX_CMD_A:
                        begin
                            if (data_reg[6:4] == CMD_RESET_MR)
                                mp_a_next = 1'b0;
                        end
                        IDX_CMD_B:
                        begin
                            if (data_reg[6:4] == CMD_RESET_MR)
                                mp_b_next = 1'b0;
                        end
                        // transmitter status bits are already set, nothing to store
                        IDX_HOLD_A, IDX_HOLD_B:
                        begin
                            if (tx_en_reg)
                            begin
                                txv_st_next = 1'b1;
                                txc_st_next = idx_reg[3];
                                txb_st_next = data_reg;
                            end
                        end
                        default: rf_next[idx_reg] = data_reg;
                    endcase
                end
                ACT_FEED:
                begin
                    // ring full when the advanced tail would meet the head
                    if (feed_tail_inc == feed_head)
                        drop_st_next = 1'b1;
                    else
                    begin
                        mem_we = 1'b1;
                        if (ch_reg)
                            tail_b_next = feed_tail_inc;
                        else
                            tail_a_next = feed_tail_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                rf_reg[i] <= 8'h00;
            mp_a_reg   <= 1'b0;
            mp_b_reg   <= 1'b0;
            head_a_reg <= '0;
            head_b_reg <= '0;
            tail_a_reg <= '0;
            tail_b_reg <= '0;
            tx_en_reg  <= 1'b1;
        end
        else
        begin
            rf_reg     <= rf_next;
            mp_a_reg   <= mp_a_next;
            mp_b_reg   <= mp_b_next;
            head_a_reg <= head_a_next;
            head_b_reg <= head_b_next;
            tail_a_reg <= tail_a_next;
            tail_b_reg <= tail_b_next;
            if (cfg_we)
                tx_en_reg <= cfg_wdata;
        end
    end

    // payload, staged result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= action;
            idx_reg  <= prod[DIV_SHIFT +: 4];
            data_reg <= data_byte;
            ch_reg   <= channel;
        end
        rd_st_reg   <= rd_st_next;
        txv_st_reg  <= txv_st_next;
        txc_st_reg  <= txc_st_next;
        txb_st_reg  <= txb_st_next;
        drop_st_reg <= drop_st_next;
        pop_st_reg  <= pop_st_next;
        // head and tail were updated at the end of exec, so flags are post-item
        if (cmd.load)
        begin
            read_data    <= pop_st_reg ? ring_rdata_reg : rd_st_reg;
            tx_valid     <= txv_st_reg;
            tx_channel   <= txc_st_reg;
            tx_byte      <= txb_st_reg;
            rx_empty_a   <= empty_a;
            rx_empty_b   <= empty_b;
            feed_dropped <= drop_st_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[mem_waddr] <= data_reg;
        if (cmd.exec)
            ring_rdata_reg <= ring_mem[mem_raddr];
    end

endmodule

// ----- sv/dual_uart_register_block.sv -----
// dual_uart_register_block: top level of the two-channel uart register model
// depends on dur_pkg, dur_ctrl and dur_datapath
//
//   channel  | signals                                           | handshake
//   ---------+---------------------------------------------------+--------------
//   input    | action, bus_offset, data_byte, channel            | in_valid/in_ready
//   output   | read_data, tx_valid, tx_channel, tx_byte,          | out_valid/out_ready
//            | rx_empty_a, rx_empty_b, feed_dropped               |
//   config   | cfg_wdata (tx_enable)                              | cfg_we, no wait
//
// each item passes in order through accept, execute and load into the output register
// the sequencer steps through these; the receive ring memory is read into a register during execute
// a new item is accepted while a result waits; its load stalls until the output is taken
// reset is asynchronous; ring contents are undefined until written, no clearing pass
module dual_uart_register_block #(
    parameter int REG_STRIDE = 4,
    parameter int RING_SLOTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [5:0] bus_offset,
    input  logic [7:0] data_byte,
    input  logic       channel,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       tx_valid,
    output logic       tx_channel,
    output logic [7:0] tx_byte,
    output logic       rx_empty_a,
    output logic       rx_empty_b,
    output logic       feed_dropped,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);
    import dur_pkg::*;

    dur_cmd_t cmd;

    dur_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    dur_datapath #(
        .REG_STRIDE (REG_STRIDE),
        .RING_SLOTS (RING_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .action       (action),
        .bus_offset   (bus_offset),
        .data_byte    (data_byte),
        .channel      (channel),
        .read_data    (read_data),
        .tx_valid     (tx_valid),
        .tx_channel   (tx_channel),
        .tx_byte      (tx_byte),
        .rx_empty_a   (rx_empty_a),
        .rx_empty_b   (rx_empty_b),
        .feed_dropped (feed_dropped)
    );

endmodule

// ----- tb/tb.sv -----
// tb: self-checking bench for dual_uart_register_block, register accesses and receive feeds
// depends on dur_pkg and dual_uart_register_block; keeps its own model of registers and rings
`timescale 1ns / 1ps

module tb;
    import dur_pkg::*;

    localparam int REG_STRIDE = 4;
    localparam int RING_SLOTS = 16;
    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;

    // action code with no function, and the top plain storage register
    localparam logic [1:0] ACT_NOP = 2'd3;
    localparam logic [3:0] IDX_SPARE_TOP = 4'd15;

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] bus_offset;
        logic [7:0] data_byte;
        logic       channel;
    } uart_op_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic       tx_channel;
        logic [7:0] tx_byte;
        logic       rx_empty_a;
        logic       rx_empty_b;
        logic       feed_dropped;
    } uart_res_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] action = '0;
    logic [5:0] bus_offset = '0;
    logic [7:0] data_byte = '0;
    logic       channel = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_data;
    logic       tx_valid;
    logic       tx_channel;
    logic [7:0] tx_byte;
    logic       rx_empty_a;
    logic       rx_empty_b;
    logic       feed_dropped;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;

    // model state
    logic [7:0] uart_regs [16];
    logic [7:0] uart_stat [2];
    logic       mode_sel [2];
    logic [7:0] rx_fifo [2][RING_SLOTS];
    int         rx_rd [2];
    int         rx_wr [2];
    logic       tx_en;

    uart_op_t  op_q [$];
    uart_res_t expected_q [$];
    uart_op_t  drv_op;
    int        src_gap = 0;
    int        snk_stall = 0;
    bit        src_burst = 1'b0;
    bit        snk_burst = 1'b0;
    int        err_count = 0;
    int        cycle_count = 0;

    dual_uart_register_block #(
        .REG_STRIDE(REG_STRIDE),
        .RING_SLOTS(RING_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .bus_offset(bus_offset),
        .data_byte(data_byte),
        .channel(channel),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .read_data(read_data),
        .tx_valid(tx_valid),
        .tx_channel(tx_channel),
        .tx_byte(tx_byte),
        .rx_empty_a(rx_empty_a),
        .rx_empty_b(rx_empty_b),
        .feed_dropped(feed_dropped),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [5:0] reg_off(input logic [3:0] idx, input int k);
        return 6'(int'(idx) * REG_STRIDE + k);
    endfunction

    function automatic uart_op_t mk_op(input logic [1:0] a, input logic [5:0] off,
                                       input logic [7:0] d, input logic ch);
        uart_op_t op;
        op.action = a;
        op.bus_offset = off;
        op.data_byte = d;
        op.channel = ch;
        return op;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // applies one item to the model and returns the result it produces
    function automatic uart_res_t apply_op(input uart_op_t op);
        uart_res_t r;
        logic [3:0] idx;
        logic c;
        int nxt;
        r = '0;
        idx = 4'(int'(op.bus_offset) / REG_STRIDE);
        c = idx[3];
        case (op.action)
            ACT_READ:
            begin
                case (idx)
                    IDX_MODE_A, IDX_MODE_B:
                        r.read_data = uart_regs[idx + 4'(mode_sel[c])];
                    IDX_STAT_A, IDX_STAT_B:
                    begin
                        if (rx_rd[c] == rx_wr[c])
                            uart_stat[c] = uart_stat[c] & ~ST_RXRDY;
                        else
                            uart_stat[c] = uart_stat[c] | ST_RXRDY;
                        r.read_data = uart_stat[c];
                    end
                    IDX_HOLD_A, IDX_HOLD_B:
                    begin
                        // empty ring reads as zero and stays put
                        if (rx_rd[c] != rx_wr[c])
                        begin
                            r.read_data = rx_fifo[c][rx_rd[c]];
                            rx_rd[c] = (rx_rd[c] + 1) % RING_SLOTS;
                        end
                    end
                    default:
                        r.read_data = uart_regs[idx];
                endcase
            end
            ACT_WRITE:
            begin
                case (idx)
                    IDX_MODE_A, IDX_MODE_B:
                    begin
                        uart_regs[idx + 4'(mode_sel[c])] = op.data_byte;
                        mode_sel[c] = 1'b1;
                    end
                    IDX_CMD_A, IDX_CMD_B:
                        if (op.data_byte[6:4] == CMD_RESET_MR)
                            mode_sel[c] = 1'b0;
                    IDX_HOLD_A, IDX_HOLD_B:
                    begin
                        if (tx_en)
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_channel = c;
                            r.tx_byte = op.data_byte;
                        end
                        uart_stat[c] = uart_stat[c] | ST_TXRDY | ST_TXEMT;
                    end
                    default:
                        uart_regs[idx] = op.data_byte;
                endcase
            end
            ACT_FEED:
            begin
                nxt = (rx_wr[op.channel] + 1) % RING_SLOTS;
                if (nxt == rx_rd[op.channel])
                    r.feed_dropped = 1'b1;
                else
                begin
                    rx_fifo[op.channel][rx_wr[op.channel]] = op.data_byte;
                    rx_wr[op.channel] = nxt;
                end
            end
            default:
                ;
        endcase
        r.rx_empty_a = (rx_rd[0] == rx_wr[0]);
        r.rx_empty_b = (rx_rd[1] == rx_wr[1]);
        return r;
    endfunction

    function automatic uart_op_t rand_op(input int feed_pct);
        uart_op_t op;
        int r;
        logic [3:0] idx;
        r = $urandom_range(0, 99);
        if (r < 3)
            op.action = ACT_NOP;
        else if (r < 3 + feed_pct)
            op.action = ACT_FEED;
        else if ($urandom_range(0, 1) == 0)
            op.action = ACT_READ;
        else
            op.action = ACT_WRITE;
        case ($urandom_range(0, 11))
            0: idx = IDX_MODE_A;
            1: idx = IDX_STAT_A;
            2: idx = IDX_CMD_A;
            3: idx = IDX_HOLD_A;
            4: idx = IDX_MODE_B;
            5: idx = IDX_STAT_B;
            6: idx = IDX_CMD_B;
            7: idx = IDX_HOLD_B;
            default: idx = 4'($urandom);
        endcase
        op.bus_offset = reg_off(idx, $urandom_range(0, REG_STRIDE - 1));
        op.data_byte = 8'($urandom);
        if ((idx == IDX_CMD_A || idx == IDX_CMD_B) && $urandom_range(0, 2) == 0)
            op.data_byte[6:4] = CMD_RESET_MR;
        op.channel = 1'($urandom);
        return op;
    endfunction

    task automatic set_tx_enable(input logic v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tx_en = v;
    endtask

    // sampled at the falling edge so the driver's updates have settled
    task automatic wait_drained();
        while (op_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // driver: one item at a time, held until accepted
    always @(posedge clk or negedge rst_n)
    begin : drv
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= '0;
            bus_offset <= '0;
            data_byte <= '0;
            channel <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_q.push_back(apply_op(drv_op));
            if (in_valid && !in_ready)
                ;
            else if (src_gap > 0)
            begin
                src_gap--;
                in_valid <= 1'b0;
            end
            else if (op_q.size() > 0)
            begin
                drv_op = op_q.pop_front();
                in_valid <= 1'b1;
                action <= drv_op.action;
                bus_offset <= drv_op.bus_offset;
                data_byte <= drv_op.data_byte;
                channel <= drv_op.channel;
                src_gap = src_burst ? 0 : pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: compares each result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : mon
        uart_res_t got;
        uart_res_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                got.read_data = read_data;
                got.tx_valid = tx_valid;
                got.tx_channel = tx_channel;
                got.tx_byte = tx_byte;
                got.rx_empty_a = rx_empty_a;
                got.rx_empty_b = rx_empty_b;
                got.feed_dropped = feed_dropped;
                if (expected_q.size() == 0)
                begin
                    $error("result with no item outstanding");
                    err_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                        err_count++;
                    if (got.read_data !== want.read_data)
                        $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
                    if (got.tx_valid !== want.tx_valid)
                        $error("tx_valid: expected %0d, got %0d", want.tx_valid, got.tx_valid);
                    if (got.tx_channel !== want.tx_channel)
                        $error("tx_channel: expected %0d, got %0d",
                               want.tx_channel, got.tx_channel);
                    if (got.tx_byte !== want.tx_byte)
                        $error("tx_byte: expected %0h, got %0h", want.tx_byte, got.tx_byte);
                    if (got.rx_empty_a !== want.rx_empty_a)
                        $error("rx_empty_a: expected %0d, got %0d",
                               want.rx_empty_a, got.rx_empty_a);
                    if (got.rx_empty_b !== want.rx_empty_b)
                        $error("rx_empty_b: expected %0d, got %0d",
                               want.rx_empty_b, got.rx_empty_b);
                    if (got.feed_dropped !== want.feed_dropped)
                        $error("feed_dropped: expected %0d, got %0d",
                               want.feed_dropped, got.feed_dropped);
                end
                snk_stall = snk_burst ? 0 : pick_gap();
            end
            if (snk_stall > 0)
            begin
                snk_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : timeout
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : main
        int sent;
        int n;
        int feed_pct;
        logic tx_next;
        sent = 0;
        tx_next = 1'b0;
        for (int i = 0; i < 16; i++)
            uart_regs[i] = 8'h00;
        for (int c = 0; c < 2; c++)
        begin
            uart_stat[c] = ST_TXRDY | ST_TXEMT;
            mode_sel[c] = 1'b0;
            rx_rd[c] = 0;
            rx_wr[c] = 0;
        end
        tx_en = 1'b1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_tx_enable(1'b1);

        // mode pointer steps to mr2, command resets it even with bit 7 set
        op_q.push_back(mk_op(ACT_WRITE, reg_off(IDX_MODE_A, 0), 8'hA5, 1'b0));
        op_q.push_back(mk_op(ACT_WRITE, reg_off(IDX_MODE_A, 1), 8'h5A, 1'b0));
        op_q.push_back(mk_op(ACT_WRITE, reg_off(IDX_CMD_A, 0), 8'h90, 1'b0));
        op_q.push_back(mk_op(ACT_READ, reg_off(IDX_MODE_A, 3), 8'h00, 1'b1));
        op_q.push_back(mk_op(ACT_WRITE, reg_off(IDX_HOLD_A, 0), 8'hFF, 1'b1));
        // status index write lands in storage, read returns live status
        op_q.push_back(mk_op(ACT_WRITE, reg_off(IDX_STAT_B, 0), 8'h77, 1'b0));
        op_q.push_back(mk_op(ACT_READ, reg_off(IDX_STAT_B, 0), 8'h00, 1'b0));
        op_q.push_back(mk_op(ACT_WRITE, reg_off(IDX_SPARE_TOP, 3), 8'h81, 1'b0));
        op_q.push_back(mk_op(ACT_READ, reg_off(IDX_SPARE_TOP, 0), 8'h00, 1'b0));
        op_q.push_back(mk_op(ACT_NOP, 6'h3F, 8'hFF, 1'b1));
        // fill ring b until the last byte is dropped
        for (int k = 0; k < RING_SLOTS; k++)
            op_q.push_back(mk_op(ACT_FEED, 6'h00, 8'(k * 17), 1'b1));
        op_q.push_back(mk_op(ACT_READ, reg_off(IDX_STAT_B, 2), 8'h00, 1'b0));
        op_q.push_back(mk_op(ACT_READ, reg_off(IDX_HOLD_B, 0), 8'h00, 1'b0));
        op_q.push_back(mk_op(ACT_READ, reg_off(IDX_HOLD_A, 0), 8'h00, 1'b0));
        wait_drained();

        while (sent < RANDOM_ITEMS)
        begin
            set_tx_enable(tx_next);
            tx_next = ~tx_next;
            n = $urandom_range(60, 200);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            case ($urandom_range(0, 2))
                0: feed_pct = 10;
                1: feed_pct = 25;
                default: feed_pct = 60;
            endcase
            src_burst = ($urandom_range(0, 3) == 0);
            snk_burst = ($urandom_range(0, 3) == 0);
            @(negedge clk);
            for (int i = 0; i < n; i++)
                op_q.push_back(rand_op(feed_pct));
            sent += n;
            wait_drained();
        end

        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
